/* rtl/kit_pkg.sv */
// kit_pkg: command, status and sequencer state codes for the keyed identifier table
// shared by keyed_identifier_table and kit_checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kit_pkg;

  localparam int KEY_W   = 31;
  localparam int VALUE_W = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_SET    = 2'd2,
    CMD_GET    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* rtl/keyed_identifier_table.sv */
// keyed_identifier_table: bounded key to (type, number) store held in one synchronous memory
// depends on kit_pkg; checked by kit_assertions (bound in its own file)
`timescale 1ns / 1ps
`default_nettype none

// Each item is one command (insert/replace, erase, set existing, get) on a table of
// TABLE_DEPTH entries kept in a single memory with one write and one registered read
// port. Every command walks the whole memory one entry per cycle, looking for the
// entry with the same key and the lowest free entry, then does at most one write back.
// The first read is issued while idle; the scan is followed by a write-back state and
// a done state that loads the result register. One item is handled at a time: a new
// item is accepted only in idle, and the done state waits while a held result is not
// taken. The result register lets the next item be accepted while the previous result
// still waits. After reset a clearing pass marks every entry free; in_stall is high
// during it.
module keyed_identifier_table
  import kit_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int TYPE_BITS   = 4
) (
  input  wire                       clk,
  input  wire                       rst_n,
  // command channel
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [1:0]                in_command,
  input  wire  [KEY_W-1:0]          in_key,
  input  wire  [TYPE_BITS-1:0]      in_entry_type,
  input  wire  signed [VALUE_W-1:0] in_entry_value,
  // result channel
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [1:0]                out_status,
  output logic [TYPE_BITS-1:0]      out_type_out,
  output logic signed [VALUE_W-1:0] out_value_out
);

  // memory word: {valid, key, type, number}
  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int WORD_W = 1 + KEY_W + TYPE_BITS + VALUE_W;
  localparam int V_BIT  = WORD_W - 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r;

  // captured command
  cmd_t                  cmd_r;
  logic [KEY_W-1:0]      key_r;
  logic [TYPE_BITS-1:0]  type_r;
  logic [VALUE_W-1:0]    value_r;

  // scan results
  logic                  match_found_r;
  logic [AW-1:0]         match_idx_r;
  logic [TYPE_BITS-1:0]  match_type_r;
  logic [VALUE_W-1:0]    match_value_r;
  logic                  free_found_r;
  logic [AW-1:0]         free_idx_r;

  // result waiting for the output register
  status_t               res_status_r, res_status;
  logic [TYPE_BITS-1:0]  res_type_r, res_type;
  logic [VALUE_W-1:0]    res_value_r, res_value;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [TYPE_BITS-1:0]  out_type_r;
  logic [VALUE_W-1:0]    out_value_r;

  logic in_accept;
  logic out_free;
  logic rd_hit;
  logic rd_empty;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // entry under examination in the scan is the one at cnt_r
  assign rd_hit   = rd_data_r[V_BIT] && (rd_data_r[V_BIT-1 -: KEY_W] == key_r);
  assign rd_empty = !rd_data_r[V_BIT];

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (cnt_r == LAST_IDX) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_accept) state_nxt = ST_SCAN;
      ST_SCAN:  if (cnt_r == LAST_IDX) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- outputs and write back
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    rd_addr    = '0;
    mem_we     = 1'b0;
    mem_waddr  = match_idx_r;
    mem_wdata  = {1'b1, key_r, type_r, value_r};
    res_status = STAT_OK;
    res_type   = '0;
    res_value  = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
      end
      ST_SCAN: begin
        // prefetch the next entry; wraps harmlessly on the last one
        rd_addr = cnt_r + AW'(1);
      end
      ST_WRITE: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (match_found_r) begin
              mem_we = 1'b1;
            end else if (free_found_r) begin
              mem_we    = 1'b1;
              mem_waddr = free_idx_r;
            end else begin
              res_status = STAT_FULL;
            end
          end
          CMD_ERASE: begin
            if (match_found_r) begin
              mem_we    = 1'b1;
              mem_wdata = '0;
              res_type  = match_type_r;
              res_value = match_value_r;
            end else begin
              res_status = STAT_MISSING;
            end
          end
          CMD_SET: begin
            if (match_found_r) begin
              mem_we = 1'b1;
            end else begin
              res_status = STAT_MISSING;
            end
          end
          CMD_GET: begin
            if (match_found_r) begin
              res_type  = match_type_r;
              res_value = match_value_r;
            end else begin
              res_status = STAT_MISSING;
            end
          end
          default: res_status = STAT_MISSING;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // counter drives both the clearing pass and the scan
      if (state_r == ST_CLEAR || state_r == ST_SCAN) begin
        cnt_r <= cnt_r + AW'(1);
      end else begin
        cnt_r <= '0;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r         <= cmd_t'(in_command);
      key_r         <= in_key;
      type_r        <= in_entry_type;
      value_r       <= in_entry_value;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      // keys are unique, so at most one entry hits
      if (rd_hit) begin
        match_found_r <= 1'b1;
        match_idx_r   <= cnt_r;
        match_type_r  <= rd_data_r[VALUE_W +: TYPE_BITS];
        match_value_r <= rd_data_r[VALUE_W-1:0];
      end
      // lowest free slot wins
      if (rd_empty && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cnt_r;
      end
    end
    if (state_r == ST_WRITE) begin
      res_status_r <= res_status;
      res_type_r   <= res_type;
      res_value_r  <= res_value;
    end
    if (state_r == ST_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_type_r   <= res_type_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_type_out  = out_type_r;
  assign out_value_out = out_value_r;

endmodule

`default_nettype wire

/* rtl/kit_checker.sv */
// kit_assertions: port-level assertions for keyed_identifier_table, plus the bind that attaches them
// depends on kit_pkg and keyed_identifier_table
`timescale 1ns / 1ps
`default_nettype none

module kit_assertions
  import kit_pkg::*;
#(
  parameter int TYPE_BITS = 4
) (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_stall,
  input wire  [1:0]                in_command,
  input wire  [KEY_W-1:0]          in_key,
  input wire  [TYPE_BITS-1:0]      in_entry_type,
  input wire  signed [VALUE_W-1:0] in_entry_value,
  input wire                       out_valid,
  input wire                       out_stall,
  input wire  [1:0]                out_status,
  input wire  [TYPE_BITS-1:0]      out_type_out,
  input wire  signed [VALUE_W-1:0] out_value_out
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_type_out)
                               && $stable(out_value_out))
    else $error("stalled result changed");

  // failed commands return zero contents
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_type_out == '0) && (out_value_out == '0))
    else $error("nonzero contents on failed command");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous one is in flight");

  // clearing pass holds off items after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block ready before clearing pass");

endmodule

bind keyed_identifier_table kit_assertions #(.TYPE_BITS(TYPE_BITS)) u_kit_assertions (.*);

`default_nettype wire

/* bench/kit_checker.sv */
// kit_checker: watches both channels of keyed_identifier_table, predicts each result, compares
// depends on kit_pkg for widths and codes; instantiated by tb_top beside the block
`timescale 1ns / 1ps

module kit_checker
  import kit_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int TYPE_BITS   = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  wire [1:0]           in_command,
  input  wire [KEY_W-1:0]     in_key,
  input  wire [TYPE_BITS-1:0] in_entry_type,
  input  wire [VALUE_W-1:0]   in_entry_value,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  wire [1:0]           out_status,
  input  wire [TYPE_BITS-1:0] out_type_out,
  input  wire [VALUE_W-1:0]   out_value_out,
  output int                  error_count,
  output int                  pending_count
);

  typedef struct packed {
    status_t              status;
    logic [TYPE_BITS-1:0] kind;
    logic [VALUE_W-1:0]   number;
  } reply_t;

  // shadow copy of the table
  bit                   shadow_used   [TABLE_DEPTH];
  logic [KEY_W-1:0]     shadow_key    [TABLE_DEPTH];
  logic [TYPE_BITS-1:0] shadow_kind   [TABLE_DEPTH];
  logic [VALUE_W-1:0]   shadow_number [TABLE_DEPTH];

  reply_t reply_q[$];

  function automatic reply_t run_command(cmd_t cmd, logic [KEY_W-1:0] key,
                                         logic [TYPE_BITS-1:0] kind,
                                         logic [VALUE_W-1:0] number);
    reply_t r;
    int     hit;
    int     slot;
    r.status = STAT_OK;
    r.kind   = '0;
    r.number = '0;
    hit      = -1;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (hit < 0 && shadow_used[i] && shadow_key[i] == key) hit = i;
    if (cmd == CMD_INSERT) begin
      slot = hit;
      // new key takes the lowest free slot
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (slot < 0 && !shadow_used[i]) slot = i;
      if (slot < 0) begin
        r.status = STAT_FULL;
      end else begin
        shadow_used[slot]   = 1'b1;
        shadow_key[slot]    = key;
        shadow_kind[slot]   = kind;
        shadow_number[slot] = number;
      end
    end else if (hit < 0) begin
      r.status = STAT_MISSING;
    end else if (cmd == CMD_SET) begin
      shadow_kind[hit]   = kind;
      shadow_number[hit] = number;
    end else begin
      r.kind   = shadow_kind[hit];
      r.number = shadow_number[hit];
      if (cmd == CMD_ERASE) shadow_used[hit] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    int     fails;
    reply_t want;
    fails = 0;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) shadow_used[i] = 1'b0;
      reply_q.delete();
      pending_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $error("unexpected result: status %0d type_out %0d value_out %0d",
                 out_status, out_type_out, $signed(out_value_out));
          fails++;
        end else begin
          want = reply_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            fails++;
          end
          if (out_type_out !== want.kind) begin
            $error("type_out: expected %0d, actual %0d", want.kind, out_type_out);
            fails++;
          end
          if (out_value_out !== want.number) begin
            $error("value_out: expected %0d, actual %0d",
                   $signed(want.number), $signed(out_value_out));
            fails++;
          end
        end
      end
      if (in_valid && !in_stall)
        reply_q.push_back(run_command(cmd_t'(in_command), in_key, in_entry_type,
                                      in_entry_value));
      error_count   <= error_count + fails;
      pending_count <= reply_q.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// tb_top: stimulus, reset, clock, stall patterns and verdict for keyed_identifier_table
// depends on kit_pkg, keyed_identifier_table and kit_checker
`timescale 1ns / 1ps

module tb_top;
  import kit_pkg::*;

  localparam int TABLE_DEPTH    = 64;
  localparam int TYPE_BITS      = 4;
  localparam int POOL_SIZE      = 96;   // keys reused so that most commands hit
  localparam int FILL_LEN       = 68;   // a few more than the depth, so full shows up
  localparam int MIX_LEN        = 24;
  localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000; // cycles with no item moving on either channel
  localparam int DRAIN_CYCLES   = 2 * (TABLE_DEPTH + 3) + 10;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic [1:0]                  in_command     = CMD_GET;
  logic [KEY_W-1:0]            in_key         = '0;
  logic [TYPE_BITS-1:0]        in_entry_type  = '0;
  logic signed [VALUE_W-1:0]   in_entry_value = '0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic [1:0]                  out_status;
  logic [TYPE_BITS-1:0]        out_type_out;
  logic signed [VALUE_W-1:0]   out_value_out;

  int error_count;
  int pending_count;

  // idling percentages, changed per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;
  int   quiet_cycles = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  keyed_identifier_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TYPE_BITS   (TYPE_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_entry_type  (in_entry_type),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_type_out   (out_type_out),
    .out_value_out  (out_value_out)
  );

  kit_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TYPE_BITS   (TYPE_BITS)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_key         (in_key),
    .in_entry_type  (in_entry_type),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_type_out   (out_type_out),
    .out_value_out  (out_value_out),
    .error_count    (error_count),
    .pending_count  (pending_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: counts cycles in which no item moves
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  function automatic logic [TYPE_BITS-1:0] pick_kind();
    return TYPE_BITS'($urandom_range((1 << TYPE_BITS) - 1));
  endfunction

  // numbers lean on the edges of the signed range now and then
  function automatic logic signed [VALUE_W-1:0] pick_number();
    case ($urandom_range(7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // mostly pool keys, sometimes a fresh one that is almost surely absent
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(9) < 8) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return KEY_W'($urandom());
  endfunction

  // offer one item and wait until it is taken; valid stays up into the next item
  task automatic issue(cmd_t op, logic [KEY_W-1:0] key, logic [TYPE_BITS-1:0] kind,
                       logic signed [VALUE_W-1:0] number);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= op;
    in_key         <= key;
    in_entry_type  <= kind;
    in_entry_value <= number;
    do @(posedge clk); while (in_stall);
  endtask

  // fill past capacity with pokes at stored keys, some noise, then drain
  task automatic run_phase();
    int   start;
    int   slot;
    cmd_t op;
    start = $urandom_range(POOL_SIZE - 1);
    for (int i = 0; i < FILL_LEN; i++) begin
      issue(CMD_INSERT, key_pool[(start + i) % POOL_SIZE], pick_kind(), pick_number());
      if ($urandom_range(4) == 0) begin
        slot = (start + $urandom_range(i)) % POOL_SIZE;
        op   = $urandom_range(1) ? CMD_GET : CMD_SET;
        issue(op, key_pool[slot], pick_kind(), pick_number());
      end
    end
    for (int i = 0; i < MIX_LEN; i++)
      issue(cmd_t'($urandom_range(3)), pick_key(), pick_kind(), pick_number());
    for (int i = 0; i < FILL_LEN; i++) begin
      slot = (start + i) % POOL_SIZE;
      issue(CMD_ERASE, key_pool[slot], pick_kind(), pick_number());
      // a get right after the erase must miss
      if ($urandom_range(5) == 0) issue(CMD_GET, key_pool[slot], pick_kind(), pick_number());
    end
  endtask

  initial begin : stimulus
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom());

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table misses, key and value extremes, replace, set, erase
    issue(CMD_GET,    '0,            4'h0, '0);
    issue(CMD_ERASE,  '1,            4'h0, '0);
    issue(CMD_SET,    31'd5,         4'h3, 32'sd7);
    issue(CMD_INSERT, '0,            4'h0, 32'sh8000_0000);
    issue(CMD_INSERT, '1,            4'hf, 32'sh7fff_ffff);
    issue(CMD_GET,    '0,            4'h5, 32'sd1);
    issue(CMD_GET,    '1,            4'h5, 32'sd1);
    issue(CMD_SET,    '1,            4'h0, '1);
    issue(CMD_GET,    '1,            4'h0, '0);
    issue(CMD_INSERT, '0,            4'hf, '0);
    issue(CMD_GET,    '0,            4'h0, '0);
    issue(CMD_ERASE,  '0,            4'h0, '0);
    issue(CMD_GET,    '0,            4'h0, '0);
    issue(CMD_ERASE,  '0,            4'h0, '0);
    issue(CMD_SET,    '0,            4'hf, '1);
    issue(CMD_INSERT, 31'h2aaa_aaaa, 4'ha, 32'sh5555_5555);
    issue(CMD_GET,    31'h2aaa_aaaa, 4'h0, '0);
    issue(CMD_ERASE,  '1,            4'h0, '0);
    issue(CMD_ERASE,  31'h2aaa_aaaa, 4'h0, '0);

    // phase 1: sender mostly busy, receiver mostly stalled
    send_idle_pct  = 10;
    recv_stall_pct = 86;
    run_phase();
    // phase 2: the other way round
    send_idle_pct  = 86;
    recv_stall_pct = 10;
    run_phase();
    // phase 3: no idling, with one long receiver hold-off so the input backs up
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= 1'b1;
    run_phase();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

/* keyed_identifier_table.f */
rtl/kit_pkg.sv
rtl/keyed_identifier_table.sv
rtl/kit_checker.sv
bench/kit_checker.sv
bench/tb_top.sv
